>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int QUEUE_DEPTH   = 1024;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 11;

    // result tdata layout, lowest bit first
    localparam int POP_LSB       = 0;
    localparam int CNT_LSB       = POP_LSB + DATA_W;
    localparam int EMPTY_BIT     = CNT_LSB + ENTRY_COUNT_W;
    localparam int OUT_PAYLOAD_W = EMPTY_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_PAYLOAD_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_CLEAR      = 3'd4
    } t_req_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status_e;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } t_state_e;

    typedef struct packed {
        logic load;
    } t_ctrl_cmd;

endpackage

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: accepts requests and holds each result until taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output deq_pkg::t_ctrl_cmd o_cmd
);
    import deq_pkg::*;

    t_state_e r_state;
    t_state_e n_state;
    logic     w_ready;

    // a held result that is taken this cycle frees the slot for a new request
    assign w_ready = (r_state == S_IDLE) || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_rsp_ready && !i_req_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
            end
            S_HOLD: begin
                o_req_ready = i_rsp_ready;
                o_rsp_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
                o_rsp_valid = 1'b0;
            end
        endcase
        o_cmd.load = i_req_valid && w_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring buffer storage, front/back pointers, entry count and result registers.
// ----------------------------------------------------------------------------
module deq_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  deq_pkg::t_ctrl_cmd                    i_cmd,
    input  logic [deq_pkg::REQ_W-1:0]             i_req,
    input  logic [deq_pkg::DATA_W-1:0]            i_push_value,
    output deq_pkg::t_status_e                    o_status,
    output logic [deq_pkg::DATA_W-1:0]            o_popped_value,
    output logic [deq_pkg::CNT_W-1:0]             o_entry_count,
    output logic                                  o_is_empty
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [ADDR_W-1:0] r_front;
    logic [ADDR_W-1:0] r_back;
    logic [CNT_W-1:0]  r_count;
    t_status_e         r_status;
    logic              r_pop_ok;

    logic [ADDR_W-1:0] n_front;
    logic [ADDR_W-1:0] n_back;
    logic [CNT_W-1:0]  n_count;
    t_status_e         n_status;
    logic              n_pop_ok;

    logic [ADDR_W-1:0] w_front_inc;
    logic [ADDR_W-1:0] w_front_dec;
    logic [ADDR_W-1:0] w_back_inc;
    logic [ADDR_W-1:0] w_back_dec;
    logic              w_full;
    logic              w_empty;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);

    assign w_front_inc = (r_front == LAST_SLOT) ? '0 : r_front + ADDR_W'(1);
    assign w_front_dec = (r_front == '0) ? LAST_SLOT : r_front - ADDR_W'(1);
    assign w_back_inc  = (r_back == LAST_SLOT) ? '0 : r_back + ADDR_W'(1);
    assign w_back_dec  = (r_back == '0) ? LAST_SLOT : r_back - ADDR_W'(1);
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_status  = STAT_DONE;
        n_pop_ok  = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_back;
        w_rd_en   = 1'b0;
        w_rd_addr = r_front;
        unique case (i_req)
            REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_front_dec;
                    n_front   = w_front_dec;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_back;
                    n_back    = w_back_inc;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_front;
                    n_pop_ok  = 1'b1;
                    n_front   = w_front_inc;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_back_dec;
                    n_pop_ok  = 1'b1;
                    n_back    = w_back_dec;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            REQ_CLEAR: begin
                n_status = w_empty ? STAT_EMPTY : STAT_DONE;
                n_front  = '0;
                n_back   = '0;
                n_count  = '0;
            end
            default: begin
                // unused request codes leave the queue untouched
                n_status = STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_wr_en) begin
            r_mem[w_wr_addr] <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = r_pop_ok ? r_rd_data : '0;
    assign o_entry_count  = r_count;
    assign o_is_empty     = (r_count == '0);

endmodule

>>> rtl/core/double_ended_queue_unit.sv
// timing: a result is valid in the cycle after its request is accepted
// throughput: one request per cycle while results are taken without stall;
//   the single result register sets this, a request enters as it drains
// reset: synchronous active-low, leaves the queue empty with both pointers
//   at slot zero; storage is not cleared and is never read before written
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue on a ring buffer with push/pop at either end and clear.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [deq_pkg::DATA_W-1:0]           s_axis_tdata,  // push_value
    input  logic [deq_pkg::REQ_W-1:0]            s_axis_tuser,  // req_type
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // popped_value, entry_count, is_empty, zero pad
    output logic [deq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [deq_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);
    import deq_pkg::*;

    t_ctrl_cmd         w_cmd;
    t_status_e         w_status;
    logic [DATA_W-1:0] w_popped;
    logic [CNT_W-1:0]  w_count;
    logic              w_is_empty;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    deq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req          (s_axis_tuser),
        .i_push_value   (s_axis_tdata),
        .o_status       (w_status),
        .o_popped_value (w_popped),
        .o_entry_count  (w_count),
        .o_is_empty     (w_is_empty)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_is_empty,
                           ENTRY_COUNT_W'(w_count), w_popped};
    assign m_axis_tuser = w_status;

endmodule

>>> rtl/core/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [deq_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import deq_pkg::*;

    logic [ENTRY_COUNT_W-1:0] w_count;
    logic                     w_empty;

    assign w_count = m_axis_tdata[CNT_LSB +: ENTRY_COUNT_W];
    assign w_empty = m_axis_tdata[EMPTY_BIT];

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_empty == (w_count == '0)))
        else $error("empty flag disagrees with count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_count <= ENTRY_COUNT_W'(QUEUE_DEPTH)))
        else $error("entry count beyond depth");

    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser != STAT_FULL) || (w_count == ENTRY_COUNT_W'(QUEUE_DEPTH)))
            && ((m_axis_tuser != STAT_EMPTY) || (w_count == '0)))
        else $error("status disagrees with count");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both stream channels of the deque unit, keeps its own copy of the
// ring buffer, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [deq_pkg::DATA_W-1:0]           s_axis_tdata,   // push_value
    input  logic [deq_pkg::REQ_W-1:0]            s_axis_tuser,   // req_type
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // popped_value, entry_count, is_empty, zero pad
    input  logic [deq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic [deq_pkg::STATUS_W-1:0]         m_axis_tuser,   // status
    output int                                   o_pending,
    output int                                   o_errors,
    output int                                   o_checked,
    output int                                   o_full_refused,
    output int                                   o_empty_status,
    output int                                   o_peak_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    typedef struct packed {
        t_status_e                  status;
        logic [DATA_W-1:0]          popped;
        logic [ENTRY_COUNT_W-1:0]   count;
        logic                       empty;
    } t_deq_result;

    logic [DATA_W-1:0]  slot_data [QUEUE_DEPTH];
    logic [ADDR_W-1:0]  head_slot;
    logic [ADDR_W-1:0]  tail_slot;
    logic [CNT_W-1:0]   occupancy;
    t_deq_result        awaited_results [$];

    initial begin
        o_pending      = 0;
        o_errors       = 0;
        o_checked      = 0;
        o_full_refused = 0;
        o_empty_status = 0;
        o_peak_count   = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t: result %0d mismatch: %s", $time, o_checked, what);
        o_errors++;
    endtask

    // index arithmetic wraps on its own since the depth is a power of two
    function automatic t_deq_result deque_apply(input logic [REQ_W-1:0] req,
                                                input logic [DATA_W-1:0] word);
        t_deq_result res;
        res.status = STAT_DONE;
        res.popped = '0;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (occupancy == QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else if (req == REQ_PUSH_FRONT) begin
                    head_slot = head_slot - 1'b1;
                    slot_data[head_slot] = word;
                    occupancy = occupancy + 1'b1;
                end else begin
                    slot_data[tail_slot] = word;
                    tail_slot = tail_slot + 1'b1;
                    occupancy = occupancy + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (occupancy == 0) begin
                    res.status = STAT_EMPTY;
                end else if (req == REQ_POP_FRONT) begin
                    res.popped = slot_data[head_slot];
                    head_slot = head_slot + 1'b1;
                    occupancy = occupancy - 1'b1;
                end else begin
                    tail_slot = tail_slot - 1'b1;
                    res.popped = slot_data[tail_slot];
                    occupancy = occupancy - 1'b1;
                end
            end
            REQ_CLEAR: begin
                res.status = (occupancy == 0) ? STAT_EMPTY : STAT_DONE;
                head_slot = '0;
                tail_slot = '0;
                occupancy = '0;
            end
            default: begin
                // undefined request codes leave the queue alone
            end
        endcase
        res.count = occupancy;
        res.empty = (occupancy == 0);
        if (res.status == STAT_FULL) o_full_refused++;
        if (res.status == STAT_EMPTY) o_empty_status++;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deq_result want;
        if (!i_rst_n) begin
            head_slot = '0;
            tail_slot = '0;
            occupancy = '0;
            awaited_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                m_axis_tuser, want.status));
                    end
                    if (m_axis_tdata[POP_LSB +: DATA_W] !== want.popped) begin
                        flag_mismatch($sformatf("popped_value %h, expected %h",
                                                m_axis_tdata[POP_LSB +: DATA_W], want.popped));
                    end
                    if (m_axis_tdata[CNT_LSB +: ENTRY_COUNT_W] !== want.count) begin
                        flag_mismatch($sformatf("entry_count %0d, expected %0d",
                                                m_axis_tdata[CNT_LSB +: ENTRY_COUNT_W],
                                                want.count));
                    end
                    if (m_axis_tdata[EMPTY_BIT] !== want.empty) begin
                        flag_mismatch($sformatf("is_empty %b, expected %b",
                                                m_axis_tdata[EMPTY_BIT], want.empty));
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] !== '0) begin
                        flag_mismatch("tdata pad bits not zero");
                    end
                end
                o_checked++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(deque_apply(s_axis_tuser, s_axis_tdata));
                if (occupancy > o_peak_count) o_peak_count = occupancy;
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

>>> tb/double_ended_queue_unit_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Drives push, pop and clear requests into the deque unit under random
// backpressure and lets the checker judge every result.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;
    localparam int               STALL_LIMIT     = 2000;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [DATA_W-1:0]       s_axis_tdata  = '0;   // push_value
    logic [REQ_W-1:0]        s_axis_tuser  = '0;   // req_type
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // popped_value, entry_count, is_empty, pad
    logic [STATUS_W-1:0]     m_axis_tuser;         // status

    int sender_idle_pct   = 18;
    int receiver_idle_pct = 51;
    int quiet_cycles      = 0;

    int pending;
    int mismatches;
    int checked;
    int full_refused;
    int empty_status;
    int peak_count;

    always #2 i_clk = ~i_clk;

    double_ended_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    double_ended_queue_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .o_pending      (pending),
        .o_errors       (mismatches),
        .o_checked      (checked),
        .o_full_refused (full_refused),
        .o_empty_status (empty_status),
        .o_peak_count   (peak_count)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("double_ended_queue_unit_test: errors");
            $finish;
        end
    end

    // corner words now and then, otherwise anything
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_random(input int n, input int push_pct);
        int               r;
        logic [REQ_W-1:0] req;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < push_pct) begin
                req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            end else if (r < 98) begin
                req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
            end else if (r == 98) begin
                req = REQ_CLEAR;
            end else begin
                req = REQ_W'($urandom_range(REQ_RESERVED_HI, REQ_RESERVED_LO));
            end
            send_request(req, rand_word());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, single element, extremes, clears, undefined codes
        send_request(REQ_POP_FRONT, 32'hffff_ffff);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_CLEAR, 32'h0);
        send_request(REQ_PUSH_FRONT, 32'h7fff_ffff);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_PUSH_BACK, 32'h8000_0000);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_PUSH_FRONT, 32'hffff_ffff);
        send_request(REQ_PUSH_BACK, 32'h0);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PUSH_BACK, 32'h7fff_ffff);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_CLEAR, 32'hffff_ffff);
        send_request(REQ_POP_BACK, 32'h0);
        for (int code = REQ_RESERVED_LO; code <= REQ_RESERVED_HI; code++) begin
            send_request(code[REQ_W-1:0], 32'hffff_ffff);
        end
        send_request(REQ_PUSH_BACK, 32'h5555_5555);
        send_request(REQ_PUSH_FRONT, 32'haaaa_aaaa);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        drain_results();

        run_random(60, 60);
        drain_results();

        sender_idle_pct   = 51;
        receiver_idle_pct = 18;
        run_random(60, 50);
        drain_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(60, 45);

        // fill from the back so the tail wraps, then churn at capacity
        send_request(REQ_CLEAR, rand_word());
        repeat (QUEUE_DEPTH) send_request(REQ_PUSH_BACK, rand_word());
        repeat (48) begin
            send_request(REQ_W'($urandom_range(REQ_POP_BACK, REQ_PUSH_FRONT)), rand_word());
        end
        send_request(REQ_CLEAR, rand_word());
        drain_results();
        repeat (4) @(posedge i_clk);

        $display("%0d results checked across three backpressure mixes, peak occupancy %0d",
                 checked, peak_count);
        $display("%0d pushes refused at capacity, %0d requests met an empty queue",
                 full_refused, empty_status);
        if (mismatches == 0) begin
            $display("double_ended_queue_unit_test: clean");
        end else begin
            $display("double_ended_queue_unit_test: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/deq_pkg.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_datapath.sv
rtl/core/double_ended_queue_unit.sv
rtl/core/deq_checker.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_unit_test.sv
